// File: sv/tgm_pkg.sv
`default_nettype none
package tgm_pkg;

  localparam int unsigned SLOTS  = 3;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned RES_MAX = 4;
  localparam int unsigned RES_W   = $clog2(RES_MAX + 1);
  localparam int unsigned ADDR_W  = 5;

  localparam logic [1:0] REQ_DOWN   = 2'd0;
  localparam logic [1:0] REQ_UP     = 2'd1;
  localparam logic [1:0] REQ_MOTION = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  localparam logic [1:0] DEV_DIRECT   = 2'd0;
  localparam logic [1:0] DEV_INDIRECT = 2'd1;

  localparam logic [1:0] EV_MOTION  = 2'd0;
  localparam logic [1:0] EV_DOWN    = 2'd1;
  localparam logic [1:0] EV_UP      = 2'd2;
  localparam logic [1:0] EV_TRIGGER = 2'd3;

  localparam logic [1:0] DRAG_OFF   = 2'd0;
  localparam logic [1:0] DRAG_TWO   = 2'd1;
  localparam logic [1:0] DRAG_THREE = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TAP    = 3'd2;
  localparam logic [2:0] REG_HOLD   = 3'd3;
  localparam logic [2:0] REG_BACK   = 3'd4;

  localparam logic [15:0] TRIG_MID = 16'd32768;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] tap_max;
    logic [15:0] click_hold;
    logic        back_en;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        button;
    logic        trig;
    logic [11:0] x;
    logic [11:0] y;
  } evt_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MULX, ST_MULY, ST_SCAN, ST_TICK, ST_DECIDE, ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: sv/tgm_if.sv
`default_nettype none
interface tgm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  device_kind;
  logic [7:0]  finger_id;
  logic [31:0] timestamp;
  logic [15:0] touch_x;
  logic [15:0] touch_y;
  logic [11:0] pointer_x;
  logic [11:0] pointer_y;
  modport source (output valid, req_type, device_kind, finger_id, timestamp,
                  touch_x, touch_y, pointer_x, pointer_y, input ready);
  modport sink (input valid, req_type, device_kind, finger_id, timestamp,
                touch_x, touch_y, pointer_x, pointer_y, output ready);
endinterface

interface tgm_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        button;
  logic        trigger_pressed;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic        last;
  modport source (output valid, event_kind, button, trigger_pressed, pos_x, pos_y,
                  last, input ready);
  modport sink (input valid, event_kind, button, trigger_pressed, pos_x, pos_y,
                last, output ready);
endinterface
`default_nettype wire

// File: sv/tgm_regs.sv
`default_nettype none
module tgm_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tgm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output tgm_pkg::cfg_t                  cfg_o
);

  tgm_pkg::cfg_t cfg_q;
  logic [2:0]    idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width      <= 12'd640;
      cfg_q.height     <= 12'd480;
      cfg_q.tap_max    <= 16'd250;
      cfg_q.click_hold <= 16'd50;
      cfg_q.back_en    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        tgm_pkg::REG_WIDTH:  cfg_q.width      <= pwdata[11:0];
        tgm_pkg::REG_HEIGHT: cfg_q.height     <= pwdata[11:0];
        tgm_pkg::REG_TAP:    cfg_q.tap_max    <= pwdata[15:0];
        tgm_pkg::REG_HOLD:   cfg_q.click_hold <= pwdata[15:0];
        tgm_pkg::REG_BACK:   cfg_q.back_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tgm_pkg::REG_WIDTH:  prdata = {20'd0, cfg_q.width};
      tgm_pkg::REG_HEIGHT: prdata = {20'd0, cfg_q.height};
      tgm_pkg::REG_TAP:    prdata = {16'd0, cfg_q.tap_max};
      tgm_pkg::REG_HOLD:   prdata = {16'd0, cfg_q.click_hold};
      tgm_pkg::REG_BACK:   prdata = {31'd0, cfg_q.back_en};
      default:             prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tgm_reach_unit.sv
`default_nettype none
// Wrapping time compare: has t reached base + offset.
module tgm_reach_unit (
  input  wire logic [31:0] t_i,
  input  wire logic [31:0] base_i,
  input  wire logic [15:0] offset_i,
  output logic             reached_o
);
  logic [31:0] target;
  logic [31:0] diff;
  assign target    = base_i + {16'd0, offset_i};
  assign diff      = t_i - target;
  assign reached_o = ~diff[31];
endmodule
`default_nettype wire

// File: sv/tgm_engine.sv
`default_nettype none
module tgm_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tgm_pkg::cfg_t cfg_i,
  tgm_req_if.sink            req_i,
  tgm_evt_if.source          evt_o
);

  localparam int unsigned SW = tgm_pkg::SLOT_W;
  localparam int unsigned CW = tgm_pkg::CNT_W;

  tgm_pkg::state_e state_q, state_d;

  logic [1:0]  req_q, dev_q;
  logic [7:0]  id_q;
  logic [31:0] ts_q;
  logic [15:0] tx_q, ty_q;
  logic [11:0] px_q, py_q, lx_q, ly_q;

  logic        busy_q [tgm_pkg::SLOTS];
  logic [7:0]  finger_q [tgm_pkg::SLOTS];
  logic [31:0] dtime_q [tgm_pkg::SLOTS];
  logic [11:0] lastx_q [tgm_pkg::SLOTS];
  logic [11:0] lasty_q [tgm_pkg::SLOTS];
  logic [11:0] firstx_q [tgm_pkg::SLOTS];
  logic [11:0] firsty_q [tgm_pkg::SLOTS];
  logic [1:0]  drag_q;
  logic [31:0] cstart_q [2];
  logic        cvalid_q [2];

  // scan results
  logic [SW-1:0] ptr_q;
  logic          phase_q;
  logic [CW-1:0] down_q, held_q;
  logic          ifound_q, iheld_q;
  logic [SW-1:0] idx_q;
  logic [11:0]   ilx_q, ily_q;
  logic          dfound_q;
  logic [SW-1:0] dslot_q;
  logic          ofound_q;
  logic [SW-1:0] oslot_q;
  logic [31:0]   ot_q;
  logic [11:0]   ofx_q, ofy_q;
  logic          c_q;

  tgm_pkg::evt_t res_q [tgm_pkg::RES_MAX];
  logic [tgm_pkg::RES_W-1:0] cnt_q;
  logic [1:0]                eptr_q;

  // shared multiplier
  logic [15:0] mul_a;
  logic [11:0] mul_b;
  logic [27:0] prod;
  assign mul_a = (state_q == tgm_pkg::ST_MULX) ? tx_q : ty_q;
  assign mul_b = (state_q == tgm_pkg::ST_MULX) ? cfg_i.width : cfg_i.height;
  assign prod  = 28'(mul_a * mul_b);

  // shared time compare
  logic [31:0] r_t, r_base;
  logic [15:0] r_off;
  logic        r_hit;

  always_comb begin
    r_t    = ts_q;
    r_base = dtime_q[ptr_q];
    r_off  = cfg_i.tap_max;
    if (state_q == tgm_pkg::ST_TICK) begin
      r_base = cstart_q[c_q];
      r_off  = cfg_i.click_hold;
    end else if (phase_q) begin
      r_t    = dtime_q[ptr_q];
      r_base = ot_q;
      r_off  = 16'd0;
    end
  end

  tgm_reach_unit u_reach (
    .t_i(r_t), .base_i(r_base), .offset_i(r_off), .reached_o(r_hit)
  );

  // decision
  tgm_pkg::evt_t dec_res [3];
  logic [1:0]    dec_n;
  logic          wr_down, clr_busy, set_click, click_sel, set_drag, upd_last;
  logic [1:0]    drag_new;
  logic          scan_end;

  assign scan_end = phase_q && (ptr_q == SW'(tgm_pkg::SLOTS - 1));

  always_comb begin
    for (int j = 0; j < 3; j++) dec_res[j] = '0;
    dec_n     = 2'd0;
    wr_down   = 1'b0;
    clr_busy  = 1'b0;
    set_click = 1'b0;
    click_sel = 1'b0;
    set_drag  = 1'b0;
    drag_new  = tgm_pkg::DRAG_OFF;
    upd_last  = 1'b0;
    if (dev_q != tgm_pkg::DEV_DIRECT) begin
      if (cfg_i.back_en && dev_q == tgm_pkg::DEV_INDIRECT && req_q != tgm_pkg::REQ_MOTION) begin
        dec_res[0].kind   = tgm_pkg::EV_TRIGGER;
        dec_res[0].button = tx_q > tgm_pkg::TRIG_MID;
        dec_res[0].trig   = req_q == tgm_pkg::REQ_DOWN;
        dec_n = 2'd1;
      end
    end else if (req_q == tgm_pkg::REQ_DOWN) begin
      wr_down = dfound_q;
    end else if (ifound_q) begin
      if (req_q == tgm_pkg::REQ_UP) begin
        clr_busy = 1'b1;
        if (drag_q == tgm_pkg::DRAG_OFF) begin
          if (!iheld_q && (down_q == CW'(1) || down_q == CW'(2))) begin
            set_click = 1'b1;
            click_sel = down_q == CW'(2);
            dec_res[0] = '{kind: tgm_pkg::EV_DOWN, button: click_sel, trig: 1'b0,
                           x: lx_q, y: ly_q};
            dec_n = 2'd1;
          end
        end else if (down_q == CW'(1)) begin
          dec_res[0] = '{kind: tgm_pkg::EV_UP, button: drag_q == tgm_pkg::DRAG_THREE,
                         trig: 1'b0, x: px_q, y: py_q};
          dec_n    = 2'd1;
          set_drag = 1'b1;
        end
      end else begin
        if (down_q >= CW'(2) && drag_q == tgm_pkg::DRAG_OFF && held_q >= CW'(2)) begin
          set_drag = 1'b1;
          drag_new = (held_q == CW'(2)) ? tgm_pkg::DRAG_TWO : tgm_pkg::DRAG_THREE;
          dec_res[0] = '{kind: tgm_pkg::EV_MOTION, button: 1'b0, trig: 1'b0,
                         x: ofx_q, y: ofy_q};
          dec_res[1] = '{kind: tgm_pkg::EV_DOWN, button: held_q != CW'(2), trig: 1'b0,
                         x: ofx_q, y: ofy_q};
          dec_n = 2'd2;
        end
        if (lx_q != ilx_q || ly_q != ily_q) begin
          upd_last = 1'b1;
          if (down_q <= CW'(1) || oslot_q == idx_q) begin
            dec_res[dec_n] = '{kind: tgm_pkg::EV_MOTION, button: 1'b0, trig: 1'b0,
                               x: lx_q, y: ly_q};
            dec_n = dec_n + 2'd1;
          end
        end
      end
    end
  end

  // sequencer
  logic out_fire;
  assign out_fire = evt_o.valid && evt_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgm_pkg::ST_IDLE:   if (req_i.valid) state_d = tgm_pkg::ST_MULX;
      tgm_pkg::ST_MULX:   state_d = tgm_pkg::ST_MULY;
      tgm_pkg::ST_MULY: begin
        if (req_q == tgm_pkg::REQ_TICK)        state_d = tgm_pkg::ST_TICK;
        else if (dev_q != tgm_pkg::DEV_DIRECT) state_d = tgm_pkg::ST_DECIDE;
        else                                   state_d = tgm_pkg::ST_SCAN;
      end
      tgm_pkg::ST_SCAN:   if (scan_end) state_d = tgm_pkg::ST_DECIDE;
      tgm_pkg::ST_TICK:   if (c_q) state_d = tgm_pkg::ST_EMIT;
      tgm_pkg::ST_DECIDE: state_d = tgm_pkg::ST_EMIT;
      tgm_pkg::ST_EMIT: begin
        if (cnt_q == '0) state_d = tgm_pkg::ST_IDLE;
        else if (out_fire && {1'b0, eptr_q} == cnt_q - 1'b1) state_d = tgm_pkg::ST_IDLE;
      end
      default: state_d = tgm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tgm_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  assign req_i.ready = state_q == tgm_pkg::ST_IDLE;

  // input capture and scratch
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.req_type;
      dev_q <= req_i.device_kind;
      id_q  <= req_i.finger_id;
      ts_q  <= req_i.timestamp;
      tx_q  <= req_i.touch_x;
      ty_q  <= req_i.touch_y;
      px_q  <= req_i.pointer_x;
      py_q  <= req_i.pointer_y;
    end
    if (state_q == tgm_pkg::ST_MULX) lx_q <= prod[27:16];
    if (state_q == tgm_pkg::ST_MULY) begin
      ly_q     <= prod[27:16];
      down_q   <= '0;
      held_q   <= '0;
      ifound_q <= 1'b0;
      dfound_q <= 1'b0;
      ofound_q <= 1'b0;
    end
    if (state_q == tgm_pkg::ST_SCAN && busy_q[ptr_q]) begin
      if (!phase_q) begin
        down_q <= down_q + CW'(1);
        if (r_hit) held_q <= held_q + CW'(1);
        if (finger_q[ptr_q] == id_q) begin
          ifound_q <= 1'b1;
          idx_q    <= ptr_q;
          iheld_q  <= r_hit;
          ilx_q    <= lastx_q[ptr_q];
          ily_q    <= lasty_q[ptr_q];
        end
      end else if (!ofound_q || !r_hit) begin
        ofound_q <= 1'b1;
        oslot_q  <= ptr_q;
        ot_q     <= dtime_q[ptr_q];
        ofx_q    <= firstx_q[ptr_q];
        ofy_q    <= firsty_q[ptr_q];
      end
    end
    if (state_q == tgm_pkg::ST_SCAN && !phase_q && !dfound_q &&
        (!busy_q[ptr_q] || finger_q[ptr_q] == id_q)) begin
      dfound_q <= 1'b1;
      dslot_q  <= ptr_q;
    end
    if (state_q == tgm_pkg::ST_DECIDE) begin
      for (int j = 0; j < 3; j++) res_q[j] <= dec_res[j];
      if (wr_down) begin
        finger_q[dslot_q] <= id_q;
        dtime_q[dslot_q]  <= ts_q;
        firstx_q[dslot_q] <= lx_q;
        firsty_q[dslot_q] <= ly_q;
        lastx_q[dslot_q]  <= lx_q;
        lasty_q[dslot_q]  <= ly_q;
      end
      if (upd_last) begin
        lastx_q[idx_q] <= lx_q;
        lasty_q[idx_q] <= ly_q;
      end
    end
    if (state_q == tgm_pkg::ST_TICK && cvalid_q[c_q] && r_hit) begin
      res_q[cnt_q[1:0]]        <= '{kind: tgm_pkg::EV_MOTION, button: 1'b0, trig: 1'b0,
                                    x: px_q, y: py_q};
      res_q[cnt_q[1:0] + 2'd1] <= '{kind: tgm_pkg::EV_UP, button: c_q, trig: 1'b0,
                                    x: px_q, y: py_q};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tgm_pkg::SLOTS; i++) busy_q[i] <= 1'b0;
      drag_q      <= tgm_pkg::DRAG_OFF;
      cvalid_q[0] <= 1'b0;
      cvalid_q[1] <= 1'b0;
      cstart_q[0] <= '0;
      cstart_q[1] <= '0;
      ptr_q       <= '0;
      phase_q     <= 1'b0;
      c_q         <= 1'b0;
      cnt_q       <= '0;
      eptr_q      <= '0;
    end else begin
      unique case (state_q)
        tgm_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          eptr_q <= '0;
          ptr_q  <= '0;
          phase_q <= 1'b0;
          c_q    <= 1'b0;
        end
        tgm_pkg::ST_SCAN: begin
          // two passes per slot: hold test, then age compare
          phase_q <= ~phase_q;
          if (phase_q && !scan_end) ptr_q <= ptr_q + SW'(1);
        end
        tgm_pkg::ST_TICK: begin
          c_q <= 1'b1;
          if (cvalid_q[c_q] && r_hit) begin
            cvalid_q[c_q] <= 1'b0;
            cstart_q[c_q] <= '0;
            cnt_q <= cnt_q + tgm_pkg::RES_W'(2);
          end
        end
        tgm_pkg::ST_DECIDE: begin
          cnt_q   <= tgm_pkg::RES_W'(dec_n);
          phase_q <= 1'b0;
          if (wr_down)  busy_q[dslot_q] <= 1'b1;
          if (clr_busy) busy_q[idx_q]   <= 1'b0;
          if (set_drag) drag_q <= drag_new;
          if (set_click) begin
            cvalid_q[click_sel] <= 1'b1;
            cstart_q[click_sel] <= ts_q;
          end
        end
        tgm_pkg::ST_EMIT: if (out_fire) eptr_q <= eptr_q + 2'd1;
        default: ;
      endcase
    end
  end

  assign evt_o.valid           = state_q == tgm_pkg::ST_EMIT && cnt_q != '0;
  assign evt_o.event_kind      = res_q[eptr_q].kind;
  assign evt_o.button          = res_q[eptr_q].button;
  assign evt_o.trigger_pressed = res_q[eptr_q].trig;
  assign evt_o.pos_x           = res_q[eptr_q].x;
  assign evt_o.pos_y           = res_q[eptr_q].y;
  assign evt_o.last            = {1'b0, eptr_q} == cnt_q - 1'b1;

endmodule
`default_nettype wire

// File: sv/touch_gesture_to_mouse_core.sv
`default_nettype none
// Touch gesture to mouse event converter.
// req_i takes one touch word per handshake (down, up, motion or tick); evt_o
// returns zero to four mouse or trigger words, the final one flagged by last.
// A word is taken only while the block is idle; it is then busy until every
// result has been taken on evt_o. One shared multiplier scales x then y
// (MULX, then MULY), and one shared wrapping time comparator walks the
// finger slots twice per slot (hold test, then age). A direct-screen word
// then passes through SCAN, DECIDE and EMIT, a tick through TICK and EMIT,
// and a pad word through DECIDE and EMIT; EMIT is entered even with no result.
// A stalled evt_o holds its word and the block accepts nothing until it drains.
// Configuration sits on an APB port, registers at byte address 4*index, and
// is to be written only while idle; the block itself does not enforce this.
// Reset clears the finger table, drag mode and pending clicks and loads the
// register defaults; no clearing pass is needed.
module touch_gesture_to_mouse_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tgm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  tgm_req_if.sink                         req_i,
  tgm_evt_if.source                       evt_o
);

  tgm_pkg::cfg_t cfg;

  tgm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  tgm_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .req_i(req_i), .evt_o(evt_o)
  );

endmodule
`default_nettype wire

// File: sv/tgm_checker.sv
`default_nettype none
module tgm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i,
  input wire logic pready_i
);

  // results are only shown while no new word can enter
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("output valid while input ready");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_last_i)))
    else $error("stalled output dropped");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i) else $error("pready low");

endmodule

bind touch_gesture_to_mouse_core tgm_checker u_tgm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(evt_o.valid), .out_ready_i(evt_o.ready),
  .out_last_i(evt_o.last), .pready_i(pready)
);
`default_nettype wire

// File: tb/tb_touch_gesture_to_mouse_core.sv
`default_nettype none
module tb_touch_gesture_to_mouse_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tgm_pkg::*;

  localparam int WATCH_LIMIT = 4000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [1:0]  req;
    logic [1:0]  dev;
    logic [7:0]  id;
    logic [31:0] ts;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [11:0] px;
    logic [11:0] py;
  } touch_t;

  typedef struct packed {
    evt_t ev;
    logic last;
  } mouse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  tgm_req_if req_if();
  tgm_evt_if evt_if();

  touch_gesture_to_mouse_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_i(req_if), .evt_o(evt_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.req_type = '0; req_if.device_kind = '0;
    req_if.finger_id = '0; req_if.timestamp = '0; req_if.touch_x = '0;
    req_if.touch_y = '0; req_if.pointer_x = '0; req_if.pointer_y = '0;
    evt_if.ready = 1'b0;
  end

  // gesture predictor state
  cfg_t        cfg_m;
  bit          fin_busy[SLOTS];
  logic [7:0]  fin_id[SLOTS];
  logic [31:0] fin_down[SLOTS];
  logic [11:0] fin_lx[SLOTS], fin_ly[SLOTS], fin_fx[SLOTS], fin_fy[SLOTS];
  logic [1:0]  drag_m;
  logic [31:0] click_t[2];
  bit          click_v[2];

  touch_t touch_q[$];
  mouse_t mouse_q[$];
  touch_t cur_touch;
  int errors = 0;
  int idle_cycles = 0;
  int req_gap = 0;
  int evt_stall = 0;
  logic [31:0] now;

  function automatic bit reached(logic [31:0] t, logic [31:0] u);
    logic [31:0] d;
    d = t - u;
    return !d[31];
  endfunction

  function automatic int oldest_finger();
    int first;
    logic [31:0] t;
    first = -1;
    t = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!fin_busy[i]) continue;
      if (first < 0 || !reached(fin_down[i], t)) begin
        first = i;
        t = fin_down[i];
      end
    end
    return first;
  endfunction

  function automatic void push_mouse(logic [1:0] k, logic b, logic tr, logic [11:0] x,
                                     logic [11:0] y);
    mouse_t m;
    m.ev.kind = k; m.ev.button = b; m.ev.trig = tr; m.ev.x = x; m.ev.y = y;
    m.last = 1'b0;
    mouse_q.push_back(m);
  endfunction

  function automatic void predict_touch(touch_t w);
    int n0, down, idx, held, f, c;
    logic [27:0] px28, py28;
    logic [11:0] lx, ly;
    n0 = mouse_q.size();
    px28 = w.tx * cfg_m.width;
    py28 = w.ty * cfg_m.height;
    lx = px28[27:16];
    ly = py28[27:16];
    if (w.req == REQ_TICK) begin
      for (c = 0; c < 2; c++) begin
        if (!click_v[c] || !reached(w.ts, click_t[c] + cfg_m.click_hold)) continue;
        click_v[c] = 0;
        click_t[c] = '0;
        push_mouse(EV_MOTION, 1'b0, 1'b0, w.px, w.py);
        push_mouse(EV_UP, c[0], 1'b0, w.px, w.py);
      end
    end else if (w.dev != DEV_DIRECT) begin
      if (cfg_m.back_en && w.dev == DEV_INDIRECT && w.req != REQ_MOTION)
        push_mouse(EV_TRIGGER, w.tx > TRIG_MID, w.req == REQ_DOWN, 12'd0, 12'd0);
    end else if (w.req == REQ_DOWN) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (fin_busy[i] && fin_id[i] != w.id) continue;
        fin_busy[i] = 1; fin_id[i] = w.id; fin_down[i] = w.ts;
        fin_fx[i] = lx; fin_lx[i] = lx; fin_fy[i] = ly; fin_ly[i] = ly;
        break;
      end
    end else begin
      down = 0; idx = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (fin_busy[i]) begin
          if (fin_id[i] == w.id) idx = i;
          down++;
        end
      end
      if (idx >= 0 && w.req == REQ_UP) begin
        fin_busy[idx] = 0;
        if (drag_m == DRAG_OFF) begin
          if (!reached(w.ts, fin_down[idx] + cfg_m.tap_max) && (down == 1 || down == 2)) begin
            c = (down == 2) ? 1 : 0;
            click_t[c] = w.ts;
            click_v[c] = 1;
            push_mouse(EV_DOWN, c[0], 1'b0, lx, ly);
          end
        end else if (down == 1) begin
          push_mouse(EV_UP, drag_m == DRAG_THREE, 1'b0, w.px, w.py);
          drag_m = DRAG_OFF;
        end
      end else if (idx >= 0) begin
        if (down >= 2 && drag_m == DRAG_OFF) begin
          held = 0;
          for (int i = 0; i < SLOTS; i++)
            if (fin_busy[i] && reached(w.ts, fin_down[i] + cfg_m.tap_max)) held++;
          if (held >= 2) begin
            f = oldest_finger();
            if (f < 0) f = idx;
            drag_m = (held == 2) ? DRAG_TWO : DRAG_THREE;
            push_mouse(EV_MOTION, 1'b0, 1'b0, fin_fx[f], fin_fy[f]);
            push_mouse(EV_DOWN, held != 2, 1'b0, fin_fx[f], fin_fy[f]);
          end
        end
        if (lx != fin_lx[idx] || ly != fin_ly[idx]) begin
          fin_lx[idx] = lx;
          fin_ly[idx] = ly;
          if (down <= 1 || oldest_finger() == idx)
            push_mouse(EV_MOTION, 1'b0, 1'b0, lx, ly);
        end
      end
    end
    if (mouse_q.size() > n0) mouse_q[mouse_q.size()-1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // driver: one word per handshake, gaps in between
  always @(posedge clk_i) begin
    logic nv;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      nv = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predict_touch(cur_touch);
        nv = 1'b0;
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (touch_q.size() > 0) begin
          cur_touch = touch_q.pop_front();
          req_if.req_type <= cur_touch.req;
          req_if.device_kind <= cur_touch.dev;
          req_if.finger_id <= cur_touch.id;
          req_if.timestamp <= cur_touch.ts;
          req_if.touch_x <= cur_touch.tx;
          req_if.touch_y <= cur_touch.ty;
          req_if.pointer_x <= cur_touch.px;
          req_if.pointer_y <= cur_touch.py;
          nv = 1'b1;
          req_gap = pick_gap();
        end
      end
      req_if.valid <= nv;
    end
  end

  // monitor: compare each word against the oldest prediction
  always @(posedge clk_i) begin
    mouse_t got, want;
    logic nr;
    if (!rst_ni) begin
      evt_if.ready <= 1'b0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        got.ev.kind = evt_if.event_kind; got.ev.button = evt_if.button;
        got.ev.trig = evt_if.trigger_pressed; got.ev.x = evt_if.pos_x;
        got.ev.y = evt_if.pos_y; got.last = evt_if.last;
        if (mouse_q.size() == 0) begin
          report($sformatf("unexpected word %h", got));
        end else begin
          want = mouse_q.pop_front();
          if (got !== want)
            report($sformatf({"got kind %0d btn %0d trig %0d x %0d y %0d last %0d, ",
                              "want %0d %0d %0d %0d %0d %0d"},
                   got.ev.kind, got.ev.button, got.ev.trig, got.ev.x, got.ev.y, got.last,
                   want.ev.kind, want.ev.button, want.ev.trig, want.ev.x, want.ev.y,
                   want.last));
        end
      end
      if (evt_stall > 0) begin
        evt_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if ($urandom_range(0, 3) == 0) evt_stall = pick_gap();
      end
      evt_if.ready <= nr;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (evt_if.valid && evt_if.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_m.width = val[11:0];
      REG_HEIGHT: cfg_m.height = val[11:0];
      REG_TAP:    cfg_m.tap_max = val[15:0];
      REG_HOLD:   cfg_m.click_hold = val[15:0];
      REG_BACK:   cfg_m.back_en = val[0];
      default: ;
    endcase
  endtask

  task automatic add(logic [1:0] rq, logic [1:0] dv, logic [7:0] id, logic [31:0] ts,
                     logic [15:0] tx, logic [15:0] ty);
    touch_t w;
    w.req = rq; w.dev = dv; w.id = id; w.ts = ts; w.tx = tx; w.ty = ty;
    w.px = 12'($urandom); w.py = 12'($urandom);
    touch_q.push_back(w);
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] tap_span();
    return cfg_m.tap_max + 1 + $urandom_range(0, 40);
  endfunction

  task automatic gesture();
    logic [7:0] ids[3];
    int nf;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        nf = $urandom_range(1, 2);
        for (int i = 0; i < nf; i++) begin
          ids[i] = pick_id();
          add(REQ_DOWN, DEV_DIRECT, ids[i], now, 16'($urandom), 16'($urandom));
          now += $urandom_range(0, 5);
        end
        repeat ($urandom_range(0, 2))
          add(REQ_MOTION, DEV_DIRECT, ids[0], now, 16'($urandom), 16'($urandom));
        for (int i = 0; i < nf; i++) begin
          now += $urandom_range(0, 3) == 0 ? tap_span() : $urandom_range(0, cfg_m.tap_max);
          add(REQ_UP, DEV_DIRECT, ids[i], now, 16'($urandom), 16'($urandom));
        end
      end
      3, 4: begin
        nf = $urandom_range(2, 3);
        for (int i = 0; i < nf; i++) begin
          ids[i] = pick_id();
          add(REQ_DOWN, DEV_DIRECT, ids[i], now, 16'($urandom), 16'($urandom));
          now += $urandom_range(0, 5);
        end
        now += tap_span();
        repeat ($urandom_range(1, 4)) begin
          add(REQ_MOTION, DEV_DIRECT, ids[$urandom_range(0, nf-1)], now,
              16'($urandom), 16'($urandom));
          now += $urandom_range(0, 20);
        end
        for (int i = 0; i < nf; i++) begin
          add(REQ_UP, DEV_DIRECT, ids[$urandom_range(0, nf-1)], now,
              16'($urandom), 16'($urandom));
          add(REQ_UP, DEV_DIRECT, ids[i], now, 16'($urandom), 16'($urandom));
        end
      end
      5, 6: begin
        now += $urandom_range(0, 1) ? cfg_m.click_hold + $urandom_range(0, 30)
                                    : $urandom_range(0, cfg_m.click_hold);
        add(REQ_TICK, 2'($urandom_range(0, 3)), 8'($urandom), now,
            16'($urandom), 16'($urandom));
      end
      7: add(2'($urandom_range(0, 3)), DEV_INDIRECT, 8'($urandom), $urandom,
             16'($urandom), 16'($urandom));
      8: add(REQ_MOTION, DEV_DIRECT, pick_id(), now, 16'($urandom), 16'($urandom));
      default: add(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom),
                   $urandom, 16'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic drain();
    while (touch_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (mouse_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    cfg_m.width = 12'd640; cfg_m.height = 12'd480; cfg_m.tap_max = 16'd250;
    cfg_m.click_hold = 16'd50; cfg_m.back_en = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      fin_busy[i] = 0; fin_id[i] = '0; fin_down[i] = '0;
      fin_lx[i] = '0; fin_ly[i] = '0; fin_fx[i] = '0; fin_fy[i] = '0;
    end
    drag_m = DRAG_OFF;
    click_t[0] = '0; click_t[1] = '0; click_v[0] = 0; click_v[1] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: pads, taps, clicks at time zero, table full, drags
    add(REQ_DOWN, DEV_INDIRECT, 8'd0, 32'd0, 16'hFFFF, 16'h0);
    add(REQ_UP, DEV_INDIRECT, 8'd0, 32'd1, 16'd32768, 16'hFFFF);
    add(REQ_MOTION, DEV_INDIRECT, 8'd0, 32'd1, 16'd0, 16'd0);
    add(REQ_DOWN, 2'd2, 8'd0, 32'd1, 16'hFFFF, 16'hFFFF);
    add(REQ_UP, 2'd3, 8'd0, 32'd1, 16'hFFFF, 16'hFFFF);
    add(REQ_DOWN, DEV_DIRECT, 8'd255, 32'd0, 16'hFFFF, 16'hFFFF);
    add(REQ_UP, DEV_DIRECT, 8'd255, 32'd0, 16'hFFFF, 16'hFFFF);
    add(REQ_TICK, 2'd3, 8'd0, 32'd100, 16'd0, 16'd0);
    add(REQ_DOWN, DEV_DIRECT, 8'd1, 32'd200, 16'd100, 16'd100);
    add(REQ_DOWN, DEV_DIRECT, 8'd1, 32'd201, 16'd200, 16'd200);
    add(REQ_DOWN, DEV_DIRECT, 8'd2, 32'd202, 16'd300, 16'd300);
    add(REQ_UP, DEV_DIRECT, 8'd9, 32'd203, 16'd0, 16'd0);
    add(REQ_UP, DEV_DIRECT, 8'd2, 32'd210, 16'd400, 16'd400);
    add(REQ_TICK, DEV_DIRECT, 8'd0, 32'd400, 16'd0, 16'd0);
    add(REQ_DOWN, DEV_DIRECT, 8'd2, 32'd500, 16'd500, 16'd500);
    add(REQ_DOWN, DEV_DIRECT, 8'd3, 32'd501, 16'd600, 16'd600);
    add(REQ_DOWN, DEV_DIRECT, 8'd4, 32'd502, 16'd700, 16'd700);
    add(REQ_MOTION, DEV_DIRECT, 8'd1, 32'd900, 16'hFFFF, 16'h0);
    add(REQ_MOTION, DEV_DIRECT, 8'd3, 32'd901, 16'h8000, 16'h8000);
    add(REQ_UP, DEV_DIRECT, 8'd1, 32'd950, 16'd0, 16'd0);
    add(REQ_UP, DEV_DIRECT, 8'd2, 32'd951, 16'd0, 16'd0);
    add(REQ_UP, DEV_DIRECT, 8'd3, 32'd952, 16'd0, 16'd0);
    add(REQ_UP, DEV_DIRECT, 8'd1, 32'd952, 16'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_WIDTH, 32'd4095); write_reg(REG_HEIGHT, 32'd4095);
          write_reg(REG_TAP, 32'd0); write_reg(REG_HOLD, 32'd0); write_reg(REG_BACK, 32'd0);
        end
        2: begin
          write_reg(REG_WIDTH, 32'd1); write_reg(REG_HEIGHT, 32'd1);
          write_reg(REG_TAP, 32'd65535); write_reg(REG_HOLD, 32'd65535);
          write_reg(REG_BACK, 32'd1);
        end
        3, 4: begin
          write_reg(REG_WIDTH, $urandom_range(1, 4095));
          write_reg(REG_HEIGHT, $urandom_range(1, 4095));
          write_reg(REG_TAP, $urandom_range(0, 400));
          write_reg(REG_HOLD, $urandom_range(0, 200));
          write_reg(REG_BACK, $urandom_range(0, 1));
        end
        default: ;
      endcase
      // start near the wrap point now and then
      now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FF00;
      while (touch_q.size() < 90) gesture();
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
sv/tgm_pkg.sv
sv/tgm_if.sv
sv/tgm_regs.sv
sv/tgm_reach_unit.sv
sv/tgm_engine.sv
sv/touch_gesture_to_mouse_core.sv
sv/tgm_checker.sv
tb/tb_touch_gesture_to_mouse_core.sv
